[hdl/omrs_pkg.sv]
// Package: shared constants for the ordered multiset rank/select block.
`default_nettype none
package omrs_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int VAL_W           = 32;
    localparam int OP_W            = 3;
    localparam int ST_W            = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_RANK   = 3'd2;
    localparam logic [OP_W-1:0] OP_KTH    = 3'd3;
    localparam logic [OP_W-1:0] OP_PRED   = 3'd4;
    localparam logic [OP_W-1:0] OP_SUCC   = 3'd5;

    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
endpackage
`default_nettype wire

[hdl/omrs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module omrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hdl/ordered_multiset_rank_select.sv]
// Top level: ordered multiset with rank, select and neighbor queries on a sorted table.
// Usage:
//   s_axis_* carries one request beat: tdata[2:0] op, tdata[34:3] operand (40 bits).
//   m_axis_* carries one result beat: tdata[31:0] answer, tdata[33:32] status.
//   Ops: insert, remove, rank, kth, predecessor, successor; op 6/7 report absent.
// Storage: one RAM holds {value, count} per distinct value in ascending order,
//   with registered read data. Entries are walked in index order from 0.
// Sequence: a search walks one entry per cycle through the registered read port,
//   and the next beat is taken only after the result has moved to the output
//   register. Insert of a new value and remove of the last copy then shift the
//   tail one entry per cycle between the search stop and the top entry, unless
//   that entry is at the end of the table; search and shift cover the table once.
//   One item is in work at a time.
// Reset: used and total counts clear; RAM content needs no clearing.
// Stall: the result sits in an output register until taken; the next request
//   is taken while that result waits, but its own result waits for the slot.
`default_nettype none
module ordered_multiset_rank_select #(
    parameter int TABLE_DEPTH = omrs_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_BITS  = omrs_pkg::COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // op[2:0], operand[34:3], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata    // answer[31:0], status[33:32], zero pad
);
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int UW  = $clog2(TABLE_DEPTH + 1);
    localparam int VW  = omrs_pkg::VAL_W;
    localparam int EW  = VW + COUNT_BITS;
    localparam int TW  = UW + COUNT_BITS;
    localparam int RW  = (TW + 1 > 33) ? TW + 1 : 33;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [RW-1:0] RANK_SAT = RW'(32'h7FFF_FFFF);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_SHUP  = 3'd3;
    localparam logic [2:0] S_SHDN  = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;
    localparam logic [2:0] S_INS   = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [UW-1:0]          used_reg, used_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [omrs_pkg::OP_W-1:0] op_reg, op_next;
    logic signed [VW-1:0]   opnd_reg, opnd_next;
    logic [UW-1:0]          idx_reg, idx_next;     // entry whose data arrives now
    logic                   rdv_reg, rdv_next;     // read data valid
    logic [RW-1:0]          acc_reg, acc_next;     // rank sum or remaining k
    logic signed [VW-1:0]   prev_reg, prev_next;   // last value below operand
    logic                   hasprev_reg, hasprev_next;
    logic [UW-1:0]          pos_reg, pos_next;
    logic [COUNT_BITS-1:0]  pcnt_reg, pcnt_next;
    logic                   hit_reg, hit_next;
    logic [UW-1:0]          sh_reg, sh_next;       // shift cursor
    logic [VW-1:0]          ans_reg, ans_next;
    logic [1:0]             st_reg, st_next;
    logic                   ovld_reg, ovld_next;
    logic [VW-1:0]          oans_reg, oans_next;
    logic [1:0]             ost_reg, ost_next;

    logic                   we;
    logic [AW-1:0]          waddr, raddr;
    logic [EW-1:0]          wdata, rdata;
    logic signed [VW-1:0]   r_val;
    logic [COUNT_BITS-1:0]  r_cnt;

    assign r_val = rdata[EW-1:COUNT_BITS];
    assign r_cnt = rdata[COUNT_BITS-1:0];

    omrs_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    wire in_fire  = s_axis_tvalid && s_axis_tready;
    wire out_fire = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {6'd0, ost_reg, oans_reg};

    // Sequencer
    always_comb begin
        logic signed [VW-1:0] v;
        logic stop;
        state_next = state_reg; used_next = used_reg; total_next = total_reg;
        op_next = op_reg; opnd_next = opnd_reg; idx_next = idx_reg;
        rdv_next = 1'b0; acc_next = acc_reg; prev_next = prev_reg;
        hasprev_next = hasprev_reg; pos_next = pos_reg; pcnt_next = pcnt_reg;
        hit_next = hit_reg; sh_next = sh_reg; ans_next = ans_reg; st_next = st_reg;
        ovld_next = ovld_reg; oans_next = oans_reg; ost_next = ost_reg;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        v = opnd_reg; stop = 1'b0;
        if (out_fire) ovld_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    op_next  = s_axis_tdata[2:0];
                    opnd_next = s_axis_tdata[34:3];
                    idx_next = '0;
                    rdv_next = (used_reg != '0);
                    raddr    = '0;
                    acc_next = (s_axis_tdata[2:0] == omrs_pkg::OP_KTH)
                             ? RW'(s_axis_tdata[34:3]) : RW'(1);
                    hasprev_next = 1'b0;
                    hit_next = 1'b0;
                    pos_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // One entry per cycle; next read issued speculatively
                if (rdv_reg) begin
                    case (op_reg)
                        omrs_pkg::OP_SUCC: stop = (r_val > v);
                        omrs_pkg::OP_KTH:  stop = (acc_reg[TW-1:0] <= TW'(r_cnt));
                        default:           stop = !(r_val < v);
                    endcase
                end
                if (op_reg == omrs_pkg::OP_KTH &&
                    (v < 1 || RW'(unsigned'(v)) > RW'(total_reg))) begin
                    ans_next = '1; st_next = omrs_pkg::ST_ABSENT; state_next = S_RES;
                end else if (rdv_reg && !stop) begin
                    if (op_reg == omrs_pkg::OP_KTH) acc_next = acc_reg - RW'(r_cnt);
                    else acc_next = acc_reg + RW'(r_cnt);
                    prev_next = r_val; hasprev_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    rdv_next = (idx_reg + 1'b1 < used_reg);
                    raddr = AW'(idx_reg + 1'b1);
                end else begin
                    pos_next = idx_reg; pcnt_next = r_cnt;
                    hit_next = rdv_reg && (r_val == v);
                    state_next = S_RES;
                    case (op_reg)
                        omrs_pkg::OP_INSERT, omrs_pkg::OP_REMOVE: state_next = S_UPD;
                        omrs_pkg::OP_RANK: begin
                            ans_next = (acc_reg > RANK_SAT) ? VW'(RANK_SAT) : VW'(acc_reg);
                            st_next = omrs_pkg::ST_DONE;
                        end
                        omrs_pkg::OP_KTH: begin
                            ans_next = r_val; st_next = omrs_pkg::ST_DONE;
                        end
                        omrs_pkg::OP_PRED: begin
                            ans_next = hasprev_reg ? prev_reg : '1;
                            st_next = hasprev_reg ? omrs_pkg::ST_DONE : omrs_pkg::ST_ABSENT;
                        end
                        omrs_pkg::OP_SUCC: begin
                            ans_next = rdv_reg ? r_val : '1;
                            st_next = rdv_reg ? omrs_pkg::ST_DONE : omrs_pkg::ST_ABSENT;
                        end
                        default: begin
                            ans_next = '0; st_next = omrs_pkg::ST_ABSENT;
                        end
                    endcase
                end
            end
            S_UPD: begin
                ans_next = '0; st_next = omrs_pkg::ST_DONE; state_next = S_RES;
                if (op_reg == omrs_pkg::OP_INSERT) begin
                    if (hit_reg) begin
                        if (pcnt_reg == CNT_MAX) st_next = omrs_pkg::ST_FULL;
                        else begin
                            we = 1'b1; waddr = AW'(pos_reg);
                            wdata = {opnd_reg, pcnt_reg + 1'b1};
                            total_next = total_reg + 1'b1;
                        end
                    end else if (used_reg == UW'(TABLE_DEPTH)) begin
                        st_next = omrs_pkg::ST_FULL;
                    end else if (used_reg == pos_reg) begin
                        we = 1'b1; waddr = AW'(pos_reg);
                        wdata = {opnd_reg, COUNT_BITS'(1)};
                        used_next = used_reg + 1'b1; total_next = total_reg + 1'b1;
                    end else begin
                        // Move tail up from the top entry
                        sh_next = used_reg; raddr = AW'(used_reg - 1'b1);
                        state_next = S_SHUP;
                    end
                end else if (!hit_reg) begin
                    st_next = omrs_pkg::ST_ABSENT;
                end else if (pcnt_reg != COUNT_BITS'(1)) begin
                    we = 1'b1; waddr = AW'(pos_reg);
                    wdata = {opnd_reg, pcnt_reg - 1'b1};
                    total_next = total_reg - 1'b1;
                end else if (pos_reg + 1'b1 == used_reg) begin
                    used_next = used_reg - 1'b1; total_next = total_reg - 1'b1;
                end else begin
                    sh_next = pos_reg; raddr = AW'(pos_reg + 1'b1);
                    state_next = S_SHDN;
                end
            end
            S_SHUP: begin
                // rdata holds entry sh-1; write it to sh
                we = 1'b1; waddr = AW'(sh_reg); wdata = rdata;
                if (sh_reg - 1'b1 == pos_reg) begin
                    state_next = S_INS;
                end else begin
                    sh_next = sh_reg - 1'b1; raddr = AW'(sh_reg - 2'd2);
                end
            end
            S_SHDN: begin
                // rdata holds entry sh+1; write it to sh
                we = 1'b1; waddr = AW'(sh_reg); wdata = rdata;
                if (sh_reg + 2'd2 == used_reg) begin
                    used_next = used_reg - 1'b1; total_next = total_reg - 1'b1;
                    state_next = S_RES;
                end else begin
                    sh_next = sh_reg + 1'b1; raddr = AW'(sh_reg + 2'd2);
                end
            end
            S_INS: begin
                // place the new value in the gap left by the tail shift
                we = 1'b1; waddr = AW'(pos_reg);
                wdata = {opnd_reg, COUNT_BITS'(1)};
                used_next = used_reg + 1'b1; total_next = total_reg + 1'b1;
                ans_next = '0; st_next = omrs_pkg::ST_DONE;
                state_next = S_RES;
            end
            S_RES: begin
                if (!ovld_reg || out_fire) begin
                    ovld_next = 1'b1; oans_next = ans_reg; ost_next = st_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; used_reg <= '0; total_reg <= '0; ovld_reg <= 1'b0;
            rdv_reg <= 1'b0;
        end else begin
            state_reg <= state_next; used_reg <= used_next; total_reg <= total_next;
            ovld_reg <= ovld_next; rdv_reg <= rdv_next;
        end
        op_reg <= op_next; opnd_reg <= opnd_next; idx_reg <= idx_next;
        acc_reg <= acc_next; prev_reg <= prev_next; hasprev_reg <= hasprev_next;
        pos_reg <= pos_next; pcnt_reg <= pcnt_next; hit_reg <= hit_next;
        sh_reg <= sh_next; ans_reg <= ans_next; st_reg <= st_next;
        oans_reg <= oans_next; ost_reg <= ost_next;
    end

    // Checks
    a_used_max: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(TABLE_DEPTH)) else $error("used count above depth");
    a_total_ge_used: assert property (@(posedge aclk) disable iff (!aresetn)
        TW'(used_reg) <= total_reg) else $error("total below distinct count");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3) else $error("bad status");
endmodule
`default_nettype wire
